/* src/rllt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rllt_pkg;

    // field widths
    localparam int IDX_W    = 11;
    localparam int PERIOD_W = 16;
    localparam int PART_W   = 16;

    // period limits
    localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 16'd65500;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd30000;

    // smoothing bands on the period difference
    localparam logic [PERIOD_W-1:0] FINE_BAND   = 16'd10;
    localparam logic [PERIOD_W-1:0] COARSE_BAND = 16'd100;

    // request kinds
    typedef enum logic [0:0] {
        OP_TICK  = 1'b0,
        OP_PULSE = 1'b1
    } op_t;

endpackage

`default_nettype wire

/* src/rotation_locked_line_timer_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel | signals                                   | direction
// --------+-------------------------------------------+----------
// in      | in_valid, in_ready, op, partial_count     | into core
// out     | out_valid, out_ready, line_index,          | out of core
//         |   line_period, resynced                   |
// cfg     | cfg_valid, cfg_ready, line_offset         | into core
//
// one request per cycle sustained while the output is not stalled; a request
// that is taken sits in the input register and moves on into the output register
// the pulse path is one reciprocal multiply plus add, clamp and blend
// reset (rst_n low, async) restores period 30000, index 0, offset 0
// a stalled output holds the input register; a new request is still taken
// when the held one moves on in the same cycle
// cfg is always ready; the offset is reduced modulo LINES as it is written
// and applies to every pulse that leaves the input register after that edge

module rotation_locked_line_timer_core #(
    parameter int LINES = 1792
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire rllt_pkg::op_t                  op,
    input  wire logic [rllt_pkg::PART_W-1:0]    partial_count,

    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [rllt_pkg::IDX_W-1:0]     line_index,
    output logic      [rllt_pkg::PERIOD_W-1:0]  line_period,
    output logic                                resynced,

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [rllt_pkg::IDX_W-1:0]     line_offset
);

    import rllt_pkg::*;

    // revolution time is held as quotient and remainder by LINES, so the
    // pulse only has to divide the small leftover, never the full 32-bit sum
    localparam int RW  = $clog2(LINES);       // remainder width
    localparam int QW  = 17;                  // quotient, saturating
    localparam int XW  = 18;                  // leftover dividend width
    localparam int LW  = $clog2(LINES + 1);   // width holding LINES itself
    localparam int IW1 = LW > IDX_W + 1 ? LW : IDX_W + 1;

    // input register
    logic              stg_valid_reg;
    op_t               stg_op_reg;
    logic [PART_W-1:0] stg_part_reg;
    logic              fire;

    // output register
    logic                out_valid_reg;
    logic [IDX_W-1:0]    line_index_reg;
    logic [PERIOD_W-1:0] line_period_reg;
    logic                resynced_reg;

    // timer state
    logic [QW-1:0]       q_reg, q_next;
    logic [RW-1:0]       r_reg, r_next;
    logic [XW-1:0]       extra_reg, extra_next;   // ticks added while split is stale
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [IDX_W-1:0]    line_reg, line_next;

    // split of the current period into quotient and remainder by LINES
    logic [PERIOD_W-1:0] pq1_reg;
    logic [PERIOD_W-1:0] pq_reg;
    logic [RW-1:0]       pr_reg;
    logic [1:0]          split_wait_reg, split_wait_next;
    logic [PERIOD_W-1:0] pq1_next;
    logic [RW-1:0]       pr_next;

    // line offset, reduced modulo LINES as it is written
    logic [IDX_W-1:0]    off_reg;
    logic [IDX_W-1:0]    off_q;
    logic [IDX_W-1:0]    off_mod;

    // pulse datapath
    logic [XW-1:0]       left_sum;
    logic [XW-1:0]       left_q;
    logic [QW+1:0]       total_q;
    logic [PERIOD_W-1:0] fresh;
    logic [PERIOD_W-1:0] diff;
    logic [21:0]         blend_fine;
    logic [19:0]         blend_coarse;
    logic [PERIOD_W-1:0] period_pulse;

    // tick datapath
    logic [RW:0]         r_sum;
    logic                r_carry;
    logic [QW:0]         q_sum;
    logic [IW1-1:0]      line_inc;

    // handshakes
    assign fire      = stg_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !stg_valid_reg || fire;
    assign cfg_ready = 1'b1;

    assign out_valid   = out_valid_reg;
    assign line_index  = line_index_reg;
    assign line_period = line_period_reg;
    assign resynced    = resynced_reg;

    // dividers by LINES
    rllt_cdiv #(.LINES(LINES), .XW(XW)) u_div_left (
        .x    (left_sum),
        .quot (left_q)
    );

    rllt_cdiv #(.LINES(LINES), .XW(PERIOD_W)) u_div_period (
        .x    (period_reg),
        .quot (pq1_next)
    );

    rllt_cdiv #(.LINES(LINES), .XW(IDX_W)) u_div_offset (
        .x    (line_offset),
        .quot (off_q)
    );

    // remainders: period from its registered quotient, offset on the write
    assign pr_next = RW'(32'(period_reg) - 32'(pq1_reg) * 32'(LINES));
    assign off_mod = IDX_W'(32'(line_offset) - 32'(off_q) * 32'(LINES));

    // pulse: new period from leftover plus accumulated quotient
    always_comb
    begin
        left_sum = XW'(r_reg) + extra_reg + XW'(stg_part_reg);
        total_q  = (QW + 2)'(q_reg) + (QW + 2)'(left_q);
        if (total_q > (QW + 2)'(PERIOD_MAX))
        begin
            fresh = PERIOD_MAX;
        end
        else
        begin
            fresh = total_q[PERIOD_W-1:0];
        end

        if (fresh > period_reg)
        begin
            diff = fresh - period_reg;
        end
        else
        begin
            diff = period_reg - fresh;
        end

        blend_fine   = ((22'(period_reg) << 6) - 22'(period_reg) + 22'(fresh)) >> 6;
        blend_coarse = ((20'(period_reg) << 4) - 20'(period_reg) + 20'(fresh)) >> 4;

        if (diff < FINE_BAND)
        begin
            period_pulse = blend_fine[PERIOD_W-1:0];
        end
        else if (diff < COARSE_BAND)
        begin
            period_pulse = blend_coarse[PERIOD_W-1:0];
        end
        else
        begin
            period_pulse = fresh;
        end
    end

    // tick: add the split period, carry the remainder into the quotient, step the line
    always_comb
    begin
        r_sum   = (RW + 1)'(r_reg) + (RW + 1)'(pr_reg);
        r_carry = r_sum >= (RW + 1)'(LINES);
        q_sum   = (QW + 1)'(q_reg) + (QW + 1)'(pq_reg) + (QW + 1)'(r_carry);
        line_inc = IW1'(line_reg) + IW1'(1);
    end

    // state update
    always_comb
    begin
        q_next          = q_reg;
        r_next          = r_reg;
        extra_next      = extra_reg;
        period_next     = period_reg;
        line_next       = line_reg;
        split_wait_next = (split_wait_reg != 2'd0) ? split_wait_reg - 2'd1 : 2'd0;

        if (fire)
        begin
            case (stg_op_reg)
                OP_TICK:
                begin
                    if (split_wait_reg != 2'd0)
                    begin
                        // period just changed, its split is not ready yet
                        extra_next = extra_reg + XW'(period_reg);
                    end
                    else
                    begin
                        r_next = r_carry ? RW'(r_sum - (RW + 1)'(LINES)) : RW'(r_sum);
                        q_next = q_sum[QW] ? {QW{1'b1}} : q_sum[QW-1:0];
                    end
                    if (line_inc == IW1'(LINES))
                    begin
                        line_next = '0;
                    end
                    else
                    begin
                        line_next = line_inc[IDX_W-1:0];
                    end
                end
                OP_PULSE:
                begin
                    period_next     = period_pulse;
                    q_next          = '0;
                    r_next          = '0;
                    extra_next      = '0;
                    line_next       = off_reg;
                    split_wait_next = 2'd2;
                end
                default:
                begin
                    line_next = line_reg;
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stg_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stg_op_reg   <= op;
            stg_part_reg <= partial_count;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            line_index_reg  <= line_next;
            line_period_reg <= period_next;
            resynced_reg    <= (stg_op_reg == OP_PULSE);
        end
    end

    // timer state and period split
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg          <= '0;
            r_reg          <= '0;
            extra_reg      <= '0;
            period_reg     <= PERIOD_RESET;
            line_reg       <= '0;
            split_wait_reg <= 2'd0;
            pq1_reg        <= PERIOD_W'(32'(PERIOD_RESET) / LINES);
            pq_reg         <= PERIOD_W'(32'(PERIOD_RESET) / LINES);
            pr_reg         <= RW'(32'(PERIOD_RESET) % LINES);
            off_reg        <= '0;
        end
        else
        begin
            q_reg          <= q_next;
            r_reg          <= r_next;
            extra_reg      <= extra_next;
            period_reg     <= period_next;
            line_reg       <= line_next;
            split_wait_reg <= split_wait_next;
            pq1_reg        <= pq1_next;
            pq_reg         <= pq1_reg;
            pr_reg         <= pr_next;
            if (cfg_valid && cfg_ready)
            begin
                off_reg <= off_mod;
            end
        end
    end

endmodule

`default_nettype wire

/* src/rllt_cdiv.sv */
`timescale 1ns / 1ps
`default_nettype none

// floor(x / LINES) by reciprocal multiply, exact for every x below 2**XW
module rllt_cdiv #(
    parameter int LINES = 1792,
    parameter int XW    = 16
) (
    input  wire logic [XW-1:0] x,
    output logic      [XW-1:0] quot
);

    localparam int          LOG = $clog2(LINES);
    localparam int          SH  = XW + LOG;
    localparam int          MW  = XW + 1;
    localparam int          PW  = 2 * XW + 1;
    localparam logic [63:0] M   = ((64'd1 << SH) + 64'(LINES) - 64'd1) / 64'(LINES);

    logic [PW-1:0] prod;

    assign prod = PW'(x) * PW'(M[MW-1:0]);
    assign quot = XW'(prod >> SH);

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    import rllt_pkg::*;

    localparam int LINE_COUNT = 1792;
    // run ends here as failed, whether or not results are still coming
    localparam int unsigned CYCLE_LIMIT = 1_500_000;

    typedef struct {
        op_t               kind;
        logic [PART_W-1:0] part;
    } line_event_t;

    typedef struct packed {
        logic [IDX_W-1:0]    line;
        logic [PERIOD_W-1:0] period;
        logic                resync;
    } line_clock_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // request channel
    logic              in_valid      = 1'b0;
    logic              in_ready;
    op_t               op            = OP_TICK;
    logic [PART_W-1:0] partial_count = '0;

    // result channel
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [IDX_W-1:0]    line_index;
    logic [PERIOD_W-1:0] line_period;
    logic                resynced;

    // offset write channel
    logic             cfg_valid   = 1'b0;
    logic             cfg_ready;
    logic [IDX_W-1:0] line_offset = '0;

    // requests waiting to be offered, results waiting to be seen
    line_event_t pending_events[$];
    line_clock_t expected_clock[$];

    // handshakes seen at the last rising edge, read at the falling edge
    logic in_taken  = 1'b0;
    logic cfg_taken = 1'b0;

    // idle odds in percent, changed only between phases
    int unsigned send_idle_pct = 29;
    int unsigned recv_idle_pct = 69;
    // long receiver hold-off, raised by its own process
    logic        rx_hold       = 1'b0;

    int unsigned accepted_count = 0;
    int unsigned error_count    = 0;
    int unsigned cycle_count    = 0;

    // shadow of the line clock state
    logic [31:0]         rev_time;
    logic [PERIOD_W-1:0] kept_period;
    logic [IDX_W-1:0]    cur_line;
    logic [IDX_W-1:0]    offset_shadow;

    rotation_locked_line_timer_core #(
        .LINES(LINE_COUNT)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .partial_count(partial_count),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .line_index   (line_index),
        .line_period  (line_period),
        .resynced     (resynced),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .line_offset  (line_offset)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // one line clock step on the shadow state, giving the line, period and flag
    function automatic line_clock_t advance_line_clock(op_t kind, logic [PART_W-1:0] part);
        logic [32:0] sum;
        int unsigned fresh;
        int unsigned gap;
        int unsigned next_line;
        line_clock_t res;
        if (kind == OP_TICK)
        begin
            // a whole line elapsed: its period joins the revolution time
            sum       = {1'b0, rev_time} + kept_period;
            rev_time  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            next_line = (cur_line + 1) % LINE_COUNT;
            cur_line  = next_line[IDX_W-1:0];
        end
        else
        begin
            // close the revolution with the partial line, saturating
            sum      = {1'b0, rev_time} + part;
            rev_time = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            fresh    = rev_time / LINE_COUNT;
            if (fresh > PERIOD_MAX)
                fresh = 32'(PERIOD_MAX);
            // true distance between measured and kept period
            gap = (fresh > kept_period) ? fresh - kept_period : kept_period - fresh;
            // fine band blends 1/64, coarse band 1/16, beyond that jump
            if (gap < FINE_BAND)
                kept_period = PERIOD_W'((63 * kept_period + fresh) / 64);
            else if (gap < COARSE_BAND)
                kept_period = PERIOD_W'((15 * kept_period + fresh) / 16);
            else
                kept_period = PERIOD_W'(fresh);
            rev_time  = '0;
            // offsets past the last line fold back into range
            next_line = offset_shadow % LINE_COUNT;
            cur_line  = next_line[IDX_W-1:0];
        end
        res.line   = cur_line;
        res.period = kept_period;
        res.resync = (kind == OP_PULSE);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic push_event(input op_t kind, input logic [PART_W-1:0] part);
        line_event_t ev;
        ev.kind = kind;
        ev.part = part;
        pending_events.push_back(ev);
    endtask

    // ticks carry a random count that the block must ignore
    task automatic push_ticks(input int unsigned n);
        repeat (n) push_event(OP_TICK, 16'($urandom));
    endtask

    // block goes quiet: nothing queued, nothing offered, nothing outstanding
    task automatic wait_for_drain();
        while (pending_events.size() != 0 || in_valid || expected_clock.size() != 0)
            @(negedge clk);
        // then let the block settle before the caller goes on
        repeat (4) @(negedge clk);
    endtask

    task automatic write_line_offset(input logic [IDX_W-1:0] value);
        wait_for_drain();
        cfg_valid   <= 1'b1;
        line_offset <= value;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
        // new offset is in place for the next request
        repeat (4) @(negedge clk);
    endtask

    // revolutions of random length, mostly short, now and then a longer one
    task automatic run_random_revolutions(input int unsigned n);
        int unsigned count;
        int unsigned laps;
        logic [PART_W-1:0] part;
        count = 0;
        while (count < n)
        begin
            laps = ($urandom_range(9) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 24);
            push_ticks(laps);
            case ($urandom_range(9))
                0:       part = '0;
                1:       part = '1;
                default: part = 16'($urandom);
            endcase
            push_event(OP_PULSE, part);
            count += laps + 1;
        end
    endtask

    // request driver: a held request stays put until taken
    always @(negedge clk)
    begin : request_driver
        line_event_t ev;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                ev = pending_events.pop_front();
                op            <= ev.kind;
                partial_count <= ev.part;
                in_valid      <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result receiver: random stalls, or a solid stall while held off
    always @(negedge clk)
    begin
        if (rst_n)
            out_ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // long hold-off mid-run so the block backs up and drops in_ready
    initial
    begin : backpressure
        while (accepted_count < 300)
            @(negedge clk);
        rx_hold <= 1'b1;
        repeat (300) @(negedge clk);
        rx_hold <= 1'b0;
    end

    // monitor: predicts on each taken request, checks each result in order
    always @(posedge clk)
    begin : monitor
        line_clock_t want;
        in_taken  = in_valid && in_ready;
        cfg_taken = cfg_valid && cfg_ready;
        if (!rst_n)
        begin
            rev_time      = '0;
            kept_period   = PERIOD_RESET;
            cur_line      = '0;
            offset_shadow = '0;
        end
        else
        begin
            if (cfg_taken)
                offset_shadow = line_offset;
            if (in_taken)
            begin
                expected_clock.push_back(advance_line_clock(op, partial_count));
                accepted_count++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_clock.size() == 0)
                    report_mismatch($sformatf("result with nothing expected: line %0d period %0d",
                                              line_index, line_period));
                else
                begin
                    want = expected_clock.pop_front();
                    if (line_index !== want.line)
                        report_mismatch($sformatf("line_index %0d, expected %0d",
                                                  line_index, want.line));
                    if (line_period !== want.period)
                        report_mismatch($sformatf("line_period %0d, expected %0d",
                                                  line_period, want.period));
                    if (resynced !== want.resync)
                        report_mismatch($sformatf("resynced %0b, expected %0b",
                                                  resynced, want.resync));
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // last line wraps to line 0
        write_line_offset(11'd1791);
        push_event(OP_PULSE, 16'hFFFF);
        push_event(OP_TICK, 16'hFFFF);
        push_event(OP_TICK, 16'h0000);
        push_event(OP_PULSE, 16'h0000);

        // offsets past the last line fold back
        write_line_offset(11'd2047);
        push_event(OP_PULSE, 16'h0000);
        push_event(OP_TICK, 16'h5555);
        write_line_offset(11'd1792);
        push_event(OP_PULSE, 16'h5555);

        // small periods: measured above and below the kept one
        write_line_offset(11'd0);
        push_event(OP_PULSE, 16'hAAAA);
        push_event(OP_PULSE, 16'hFFFF);
        push_event(OP_TICK, 16'h0001);
        push_event(OP_PULSE, 16'd16128);
        push_event(OP_PULSE, 16'd25088);
        push_event(OP_PULSE, 16'h0000);
        push_event(OP_PULSE, 16'h8000);

        // random revolutions under three idle mixes
        write_line_offset(11'($urandom_range(0, 2047)));
        run_random_revolutions(460);

        write_line_offset(11'($urandom_range(0, 2047)));
        send_idle_pct <= 69;
        recv_idle_pct <= 29;
        run_random_revolutions(460);

        write_line_offset(11'($urandom_range(0, 2047)));
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        run_random_revolutions(460);

        wait_for_drain();
        repeat (8) @(negedge clk);
        if (error_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

/* sim.f */
src/rllt_pkg.sv
src/rllt_cdiv.sv
src/rotation_locked_line_timer_core.sv
tb/tb_top.sv
